### rtl/core/efr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_pkg
// Shared widths, register indexes, reset values and control types of the
// escaped frame receiver.
// ----------------------------------------------------------------------------
package efr_pkg;

	localparam int MAX_FRAME_DEF = 16;

	localparam int BYTE_W    = 8;
	localparam int POS_W     = 4;
	localparam int LEN_W     = 5;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_FLAG   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = CFG_IDX_W'(1);

	localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'h7E;
	localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h7D;
	localparam logic [BYTE_W-1:0] ESC_TO_FLAG  = 8'h01;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic load_out;
		logic load_empty;
	} efr_cmd_t;

	typedef struct packed {
		logic ends_frame;
		logic len_zero;
		logic last_byte;
		logic out_valid;
		logic out_free;
	} efr_sts_t;

endpackage

### rtl/core/efr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_if
// Channel interfaces of the escaped frame receiver: link bytes in, decoded
// frame results out, and register writes.
// ----------------------------------------------------------------------------
interface efr_byte_if;
	logic                      valid;
	logic                      ready;
	logic [efr_pkg::BYTE_W-1:0] link_byte;

	modport source (output valid, output link_byte, input ready);
	modport sink   (input valid, input link_byte, output ready);
endinterface

interface efr_frame_if;
	logic                      valid;
	logic                      ready;
	logic [efr_pkg::BYTE_W-1:0] frame_byte;
	logic [efr_pkg::POS_W-1:0]  byte_position;
	logic [efr_pkg::LEN_W-1:0]  frame_length;
	logic                      empty_frame;
	logic                      last;

	modport source (output valid, output frame_byte, output byte_position,
		output frame_length, output empty_frame, output last, input ready);
	modport sink   (input valid, input frame_byte, input byte_position,
		input frame_length, input empty_frame, input last, output ready);
endinterface

interface efr_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [efr_pkg::CFG_IDX_W-1:0] index;
	logic [efr_pkg::BYTE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/escaped_frame_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_receiver_core
// Byte-stuffed frame receiver: removes escape pairs, stores the frame and
// replays it with position, length and last marking when the flag arrives.
// ----------------------------------------------------------------------------
// usage
//   link  : one raw link byte per transaction, taken only while idle
//   frame : one decoded byte per transaction, last set on the final one; a
//           flag with nothing stored gives a single empty-frame transaction
//   cfg   : register writes (flag value, escape value), always ready;
//           unknown indexes are ignored
// replay
//   a data or escape byte leaves the link channel ready for the next byte
//   a flag stalls the link channel while the stored bytes are replayed, each
//   through the registered read of the frame store ahead of the output
//   register; an empty frame needs no read
// reset
//   clears escape state, stored count and output valid; registers return to
//   0x7E and 0x7D; the frame store is not cleared
// stall
//   a result waiting in the output register holds replay; link bytes are
//   still taken once the last result of a frame is loaded
// ----------------------------------------------------------------------------
module escaped_frame_receiver_core #(
	parameter int MAX_FRAME = efr_pkg::MAX_FRAME_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	efr_byte_if.sink           link,
	efr_frame_if.source        frame,
	efr_cfg_if.sink            cfg
);

	efr_pkg::efr_cmd_t cmd;
	efr_pkg::efr_sts_t sts;

	assign cfg.ready = 1'b1;

	efr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (link.valid),
		.in_ready (link.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	efr_dp #(
		.MAX_FRAME (MAX_FRAME)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.in_byte       (link.link_byte),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (frame.ready),
		.out_valid     (frame.valid),
		.frame_byte    (frame.frame_byte),
		.byte_position (frame.byte_position),
		.frame_length  (frame.frame_length),
		.empty_frame   (frame.empty_frame),
		.last          (frame.last)
	);

endmodule

### rtl/core/efr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_dp
// Datapath: configuration registers, escape decode, frame store memory,
// replay index and the output register.
// ----------------------------------------------------------------------------
module efr_dp #(
	parameter int MAX_FRAME = efr_pkg::MAX_FRAME_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [efr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [efr_pkg::BYTE_W-1:0]    cfg_data,
	input  logic [efr_pkg::BYTE_W-1:0]    in_byte,
	input  efr_pkg::efr_cmd_t             cmd,
	output efr_pkg::efr_sts_t             sts,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [efr_pkg::BYTE_W-1:0]    frame_byte,
	output logic [efr_pkg::POS_W-1:0]     byte_position,
	output logic [efr_pkg::LEN_W-1:0]     frame_length,
	output logic                          empty_frame,
	output logic                          last
);

	localparam int CW = $clog2(MAX_FRAME + 1);
	localparam int IW = $clog2(MAX_FRAME);

	logic [efr_pkg::BYTE_W-1:0] flag_q;
	logic [efr_pkg::BYTE_W-1:0] esc_q;
	logic                       esc_pending_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              len_q;
	logic [IW-1:0]              idx_q;
	logic [efr_pkg::BYTE_W-1:0] mem_q [MAX_FRAME];
	logic [efr_pkg::BYTE_W-1:0] rd_data_q;
	logic                       out_valid_q;

	logic                       store;
	logic [efr_pkg::BYTE_W-1:0] store_byte;
	logic                       room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= efr_pkg::FLAG_RESET;
			esc_q  <= efr_pkg::ESCAPE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				efr_pkg::REG_FLAG:   flag_q <= cfg_data;
				efr_pkg::REG_ESCAPE: esc_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode of one link byte
	always_comb begin
		store      = 1'b0;
		store_byte = in_byte;
		if (cmd.accept) begin
			if (esc_pending_q) begin
				store      = 1'b1;
				store_byte = (in_byte == efr_pkg::ESC_TO_FLAG) ? flag_q : esc_q;
			end else if (in_byte != esc_q && in_byte != flag_q) begin
				store = 1'b1;
			end
		end
	end

	assign room = count_q < CW'(MAX_FRAME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_pending_q <= 1'b0;
			count_q       <= '0;
		end else if (cmd.accept) begin
			if (esc_pending_q) begin
				esc_pending_q <= 1'b0;
			end else if (in_byte == esc_q) begin
				esc_pending_q <= 1'b1;
			end
			if (store) begin
				count_q <= room ? count_q + CW'(1) : '0;
			end else if (sts.ends_frame) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store && room) begin
			mem_q[count_q[IW-1:0]] <= store_byte;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			idx_q <= '0;
		end else if (cmd.accept && sts.ends_frame) begin
			len_q <= count_q;
			idx_q <= '0;
		end else if (cmd.load_out) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out || cmd.load_empty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_empty) begin
			frame_byte    <= '0;
			byte_position <= '0;
			frame_length  <= '0;
			empty_frame   <= 1'b1;
			last          <= 1'b1;
		end else if (cmd.load_out) begin
			frame_byte    <= rd_data_q;
			byte_position <= efr_pkg::POS_W'(idx_q);
			frame_length  <= efr_pkg::LEN_W'(len_q);
			empty_frame   <= 1'b0;
			last          <= sts.last_byte;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.ends_frame = !esc_pending_q && in_byte == flag_q && in_byte != esc_q;
		sts.len_zero   = len_q == '0;
		sts.last_byte  = (CW'(idx_q) + CW'(1)) == len_q;
		sts.out_valid  = out_valid_q;
		sts.out_free   = !out_valid_q || out_ready;
	end

	stored_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_FRAME))
		else $error("stored count above frame capacity");

endmodule

### rtl/core/efr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_ctrl
// Controller: takes link bytes while idle and sequences the replay of a
// closed frame through the store read port into the output register.
// ----------------------------------------------------------------------------
module efr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  efr_pkg::efr_sts_t sts,
	output efr_pkg::efr_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_LOAD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d        = state_q;
		cmd.accept     = 1'b0;
		cmd.rd_en      = 1'b0;
		cmd.load_out   = 1'b0;
		cmd.load_empty = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && sts.ends_frame) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (sts.out_free) begin
					if (sts.len_zero) begin
						cmd.load_empty = 1'b1;
						state_d        = S_IDLE;
					end else begin
						cmd.rd_en = 1'b1;
						state_d   = S_LOAD;
					end
				end
			end
			S_LOAD: begin
				cmd.load_out = 1'b1;
				state_d      = sts.last_byte ? S_IDLE : S_READ;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	load_into_free_register: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |-> !sts.out_valid)
		else $error("output register loaded while still occupied");

	frame_end_starts_replay: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && sts.ends_frame |=> state_q == S_READ)
		else $error("frame end did not start replay");

	result_follows_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out || cmd.load_empty |=> sts.out_valid)
		else $error("loaded result not presented");

	no_intake_during_replay: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !cmd.accept)
		else $error("link byte taken during replay");

endmodule

### verif/tb_escaped_frame_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escaped_frame_receiver_core
// Self-checking bench for the escaped frame receiver. Link bytes are sent as
// escaped frames with random content, plus broken sequences and noise. A
// scoreboard decodes every accepted byte itself and checks each replayed
// frame result field by field. The run steps through several flag and
// escape settings, including the extremes, with random source and sink
// stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_escaped_frame_receiver_core;
	import efr_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int RUN_LIMIT_NS = 2_000_000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = {CFG_IDX_W{1'b1}};

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic [POS_W-1:0]  byte_position;
		logic [LEN_W-1:0]  frame_length;
		logic              empty_frame;
		logic              last;
	} replay_beat_t;

	class frame_replay_checker;
		logic [BYTE_W-1:0] flag_byte;
		logic [BYTE_W-1:0] esc_byte;
		bit                esc_armed;
		int unsigned       fill;
		logic [BYTE_W-1:0] held [MAX_FRAME_DEF];
		replay_beat_t      replay_q [$];
		int unsigned       mismatches;
		int unsigned       beats_checked;
		int unsigned       bytes_taken;
		int unsigned       frames_closed;
		int unsigned       empty_frames;
		int unsigned       overflows;
		int unsigned       reg_writes;

		function new();
			flag_byte = FLAG_RESET;
			esc_byte  = ESCAPE_RESET;
			esc_armed = 1'b0;
			fill      = 0;
		endfunction

		function void take_reg_write(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
			reg_writes++;
			case (idx)
			REG_FLAG: begin
				flag_byte = val;
			end
			REG_ESCAPE: begin
				esc_byte = val;
			end
			default: begin
			end
			endcase
		endfunction

		function void hold_decoded(logic [BYTE_W-1:0] b);
			if (fill < MAX_FRAME_DEF) begin
				held[fill] = b;
				fill++;
			end else begin
				fill = 0;
				overflows++;
			end
		endfunction

		function void take_link_byte(logic [BYTE_W-1:0] b);
			replay_beat_t beat;
			bytes_taken++;
			if (esc_armed) begin
				esc_armed = 1'b0;
				hold_decoded(b == ESC_TO_FLAG ? flag_byte : esc_byte);
			end else if (b == esc_byte) begin
				esc_armed = 1'b1;
			end else if (b != flag_byte) begin
				hold_decoded(b);
			end else begin
				frames_closed++;
				if (fill == 0) begin
					beat = '{frame_byte: '0, byte_position: '0, frame_length: '0,
						empty_frame: 1'b1, last: 1'b1};
					replay_q.push_back(beat);
					empty_frames++;
				end else begin
					for (int i = 0; i < fill; i++) begin
						beat.frame_byte    = held[i];
						beat.byte_position = POS_W'(i);
						beat.frame_length  = LEN_W'(fill);
						beat.empty_frame   = 1'b0;
						beat.last          = (i == fill - 1);
						replay_q.push_back(beat);
					end
				end
				fill = 0;
			end
		endfunction

		function void compare(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_replay_beat(replay_beat_t got);
			replay_beat_t want;
			if (replay_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none actual byte %0h pos %0d len %0d",
					$time, got.frame_byte, got.byte_position, got.frame_length);
				return;
			end
			want = replay_q.pop_front();
			beats_checked++;
			compare("frame_byte", want.frame_byte, got.frame_byte);
			compare("byte_position", BYTE_W'(want.byte_position), BYTE_W'(got.byte_position));
			compare("frame_length", BYTE_W'(want.frame_length), BYTE_W'(got.frame_length));
			compare("empty_frame", BYTE_W'(want.empty_frame), BYTE_W'(got.empty_frame));
			compare("last", BYTE_W'(want.last), BYTE_W'(got.last));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	efr_byte_if  link_if ();
	efr_frame_if frame_if ();
	efr_cfg_if   cfg_if ();

	frame_replay_checker sb = new();

	logic [BYTE_W-1:0] link_q [$];
	int link_gap_pct;
	int frame_stall_pct;
	int sink_hold;

	escaped_frame_receiver_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.link   (link_if),
		.frame  (frame_if),
		.cfg    (cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("FAILED: results differ");
		$finish;
	end

	// result sink with random stalls and an optional long hold-off
	always @(posedge clk) begin
		if (frame_if.valid === 1'b1 && frame_if.ready === 1'b1)
			sb.check_replay_beat({frame_if.frame_byte, frame_if.byte_position,
				frame_if.frame_length, frame_if.empty_frame, frame_if.last});
		if (sink_hold > 0) begin
			frame_if.ready <= 1'b0;
			sink_hold--;
		end else begin
			frame_if.ready <= ($urandom_range(0, 99) >= frame_stall_pct);
		end
	end

	task automatic send_link(input logic [BYTE_W-1:0] b);
		while ($urandom_range(0, 99) < link_gap_pct) begin
			link_if.valid <= 1'b0;
			@(posedge clk);
		end
		link_if.valid     <= 1'b1;
		link_if.link_byte <= b;
		do @(posedge clk); while (link_if.ready !== 1'b1);
		sb.take_link_byte(b);
	endtask

	task automatic send_queued();
		while (link_q.size() != 0)
			send_link(link_q.pop_front());
		link_if.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.replay_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		sb.take_reg_write(idx, val);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// payload byte, escaped when it collides with the flag or escape value
	function automatic void push_payload(logic [BYTE_W-1:0] d);
		logic [BYTE_W-1:0] f;
		logic [BYTE_W-1:0] e;
		logic [BYTE_W-1:0] second;
		f = sb.flag_byte;
		e = sb.esc_byte;
		if (d == f || d == e) begin
			do second = BYTE_W'($urandom); while (second == ESC_TO_FLAG);
			link_q.push_back(e);
			link_q.push_back(d == f ? ESC_TO_FLAG : second);
		end else begin
			link_q.push_back(d);
		end
	endfunction

	function automatic void push_frame(int len);
		logic [BYTE_W-1:0] d;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 5) == 0)
				d = $urandom_range(0, 1) ? sb.flag_byte : sb.esc_byte;
			else
				d = BYTE_W'($urandom);
			push_payload(d);
		end
		link_q.push_back(sb.flag_byte);
	endfunction

	function automatic void build_random(int target);
		int pick;
		int len;
		while (link_q.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				len = $urandom_range(0, 7);
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(12, 16);
				if ($urandom_range(0, 19) == 0)
					len = $urandom_range(17, 20);
				push_frame(len);
			end else if (pick < 90) begin
				// flag or escape straight after an escape
				link_q.push_back(sb.esc_byte);
				link_q.push_back($urandom_range(0, 1) ? sb.flag_byte : sb.esc_byte);
				if ($urandom_range(0, 1))
					link_q.push_back(sb.flag_byte);
			end else begin
				repeat ($urandom_range(1, 4)) link_q.push_back(BYTE_W'($urandom));
			end
		end
	endfunction

	initial begin
		logic [BYTE_W-1:0] fv;
		logic [BYTE_W-1:0] ev;

		arst_n             = 1'b0;
		link_if.valid      = 1'b0;
		link_if.link_byte  = '0;
		cfg_if.valid       = 1'b0;
		cfg_if.index       = '0;
		cfg_if.data        = '0;
		frame_if.ready     = 1'b0;
		sink_hold          = 0;
		link_gap_pct       = 15;
		frame_stall_pct    = 58;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty frame, field extremes, every escape pair, then a closing flag
		link_q.push_back(sb.flag_byte);
		link_q.push_back(8'h00);
		link_q.push_back(8'hFF);
		link_q.push_back(ESC_TO_FLAG);
		link_q.push_back(sb.esc_byte);
		link_q.push_back(ESC_TO_FLAG);
		link_q.push_back(sb.esc_byte);
		link_q.push_back(8'h5E);
		link_q.push_back(sb.esc_byte);
		link_q.push_back(sb.flag_byte);
		link_q.push_back(sb.esc_byte);
		link_q.push_back(sb.esc_byte);
		link_q.push_back(sb.flag_byte);
		send_queued();
		wait_drained();

		// buffer overflow and a full-length frame first
		push_frame(MAX_FRAME_DEF + 1);
		push_frame(MAX_FRAME_DEF);
		build_random(75);
		send_queued();
		wait_drained();

		link_gap_pct    = 58;
		frame_stall_pct = 15;
		write_reg(REG_FLAG, 8'h00);
		write_reg(REG_ESCAPE, 8'hFF);
		write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), BYTE_W'($urandom));
		build_random(60);
		send_queued();
		wait_drained();

		write_reg(REG_FLAG, 8'hFF);
		write_reg(REG_ESCAPE, 8'h00);
		build_random(45);
		send_queued();
		wait_drained();

		// back-to-back source against a long sink hold-off
		link_gap_pct    = 0;
		frame_stall_pct = 0;
		fv = BYTE_W'($urandom);
		do ev = BYTE_W'($urandom); while (ev == fv);
		write_reg(REG_FLAG, fv);
		write_reg(REG_ESCAPE, ev);
		sink_hold = HOLD_CYCLES;
		build_random(55);
		send_queued();
		wait_drained();

		// flag and escape share one value, so every such byte escapes
		fv = BYTE_W'($urandom);
		write_reg(REG_FLAG, fv);
		write_reg(REG_ESCAPE, fv);
		build_random(12);
		send_queued();
		wait_drained();

		write_reg(REG_SPARE_HI, BYTE_W'($urandom));
		write_reg(REG_FLAG, FLAG_RESET);
		write_reg(REG_ESCAPE, ESCAPE_RESET);
		build_random(20);
		send_queued();
		wait_drained();

		$display("coverage: %0d link bytes, %0d frames closed (%0d empty), %0d overflows",
			sb.bytes_taken, sb.frames_closed, sb.empty_frames, sb.overflows);
		$display("coverage: %0d results checked across %0d register writes",
			sb.beats_checked, sb.reg_writes);
		if (sb.mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### sim.f
rtl/core/efr_pkg.sv
rtl/core/efr_if.sv
rtl/core/efr_dp.sv
rtl/core/efr_ctrl.sv
rtl/core/escaped_frame_receiver_core.sv
verif/tb_escaped_frame_receiver_core.sv
